@@ hw/rtl/binary_max_heap_queue_defines.svh @@
// Assertion macros shared by the binary max-heap queue RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define BMHQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define BMHQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ hw/rtl/bmhq_pkg.sv @@
// Shared types and constants for the binary max-heap queue.
// No dependencies; bmhq_engine and binary_max_heap_queue import this package.
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int KEY_W         = 32;
  localparam int OCC_W         = 8;
  localparam int HEAP_DEPTH_DEF = 128;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic signed [KEY_W-1:0] KEY_NEG_ONE = '1;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_EMPTY,
    STAT_FULL
  } bmhq_status_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    bmhq_status_t            status;
    logic [OCC_W-1:0]        occupancy;
  } bmhq_result_t;

endpackage

@@ hw/rtl/bmhq_ram.sv @@
// Generic synchronous RAM: one write port and two read ports with registered data.
// No dependencies.
`timescale 1ns / 1ps

module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ hw/rtl/bmhq_engine.sv @@
// Heap engine: sequencer for insert with sift-up and extract with sift-down.
// Depends on bmhq_pkg and bmhq_ram; assertions use binary_max_heap_queue_defines.svh.
`timescale 1ns / 1ps
`include "binary_max_heap_queue_defines.svh"

module bmhq_engine #(
  parameter int HEAP_DEPTH = bmhq_pkg::HEAP_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            req_valid,
  input  logic                            req_op,
  input  logic signed [bmhq_pkg::KEY_W-1:0] req_key,
  output logic                            req_stall,
  output logic                            res_valid,
  output bmhq_pkg::bmhq_result_t          res,
  input  logic                            res_take
);

  import bmhq_pkg::*;

  localparam int AW    = $clog2(HEAP_DEPTH);
  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int CW    = AW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_EX_LOAD,
    S_DN_CHK,
    S_DN_CMP,
    S_RESP
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [KEY_W-1:0] kout_r, kout_nxt;
  bmhq_status_t            stat_r, stat_nxt;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [KEY_W-1:0]        ram_wdata;
  logic [AW-1:0]           ram_raddr_a;
  logic [AW-1:0]           ram_raddr_b;
  logic [KEY_W-1:0]        ram_rdata_a;
  logic [KEY_W-1:0]        ram_rdata_b;

  logic [AW-1:0]           pos_m1;
  logic [AW-1:0]           parent;
  logic [CNT_W-1:0]        cnt_m1;
  logic                    cnt_full;
  logic [CW-1:0]           cnt_ext;
  logic [CW-1:0]           child_l;
  logic [CW-1:0]           child_r;
  logic                    l_ok;
  logic                    r_ok;
  logic signed [KEY_W-1:0] rd_a;
  logic signed [KEY_W-1:0] rd_b;
  logic                    take_l;
  logic                    take_r;
  logic signed [KEY_W-1:0] lv;
  logic signed [KEY_W-1:0] best_val;
  logic [AW-1:0]           best_idx;
  logic [CNT_W+OCC_W-1:0]  occ_ext;
  logic [CW-1:0]           waddr_ext;

  bmhq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (HEAP_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  assign pos_m1   = pos_r - AW'(1);
  assign parent   = pos_m1 >> 1;
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign cnt_full = (cnt_r == CNT_W'(HEAP_DEPTH));
  assign cnt_ext  = {{(CW - CNT_W){1'b0}}, cnt_r};
  assign child_l  = {1'b0, pos_r, 1'b1};
  assign child_r  = child_l + CW'(1);
  assign l_ok     = (child_l < cnt_ext);
  assign r_ok     = (child_r < cnt_ext);

  // The right child's data may come from an unused slot; r_ok masks it.
  assign rd_a     = signed'(ram_rdata_a);
  assign rd_b     = signed'(ram_rdata_b);
  assign take_l   = (rd_a > key_r);
  assign lv       = take_l ? rd_a : key_r;
  assign take_r   = r_ok && (rd_b > lv);
  assign best_val = take_r ? rd_b : rd_a;
  assign best_idx = take_r ? child_r[AW-1:0] : child_l[AW-1:0];

  assign occ_ext   = {{OCC_W{1'b0}}, cnt_r};
  assign waddr_ext = {2'b00, ram_waddr};

  // No read whose data is used falls in a write cycle, so no forwarding is needed.
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    key_nxt     = key_r;
    kout_nxt    = kout_r;
    stat_nxt    = stat_r;
    ram_we      = 1'b0;
    ram_waddr   = pos_r;
    ram_wdata   = key_r;
    ram_raddr_a = parent;
    ram_raddr_b = pos_r;

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          kout_nxt = KEY_NEG_ONE;
          stat_nxt = STAT_OK;
          if (req_op == OP_INSERT) begin
            if (cnt_full) begin
              stat_nxt  = STAT_FULL;
              state_nxt = S_RESP;
            end else begin
              key_nxt   = req_key;
              pos_nxt   = cnt_r[AW-1:0];
              cnt_nxt   = cnt_r + CNT_W'(1);
              state_nxt = S_UP_CHK;
            end
          end else begin
            if (cnt_r == '0) begin
              stat_nxt  = STAT_EMPTY;
              state_nxt = S_RESP;
            end else begin
              ram_raddr_a = '0;
              ram_raddr_b = cnt_m1[AW-1:0];
              cnt_nxt     = cnt_m1;
              state_nxt   = S_EX_LOAD;
            end
          end
        end
      end

      S_UP_CHK: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = S_RESP;
        end else begin
          ram_raddr_a = parent;
          state_nxt   = S_UP_CMP;
        end
      end

      // The new key rides in key_r; a smaller parent moves down into the hole.
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (rd_a < key_r) begin
          ram_wdata = ram_rdata_a;
          pos_nxt   = parent;
          state_nxt = S_UP_CHK;
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_EX_LOAD: begin
        kout_nxt  = rd_a;
        key_nxt   = rd_b;
        pos_nxt   = '0;
        state_nxt = (cnt_r == '0) ? S_RESP : S_DN_CHK;
      end

      S_DN_CHK: begin
        if (!l_ok) begin
          ram_we    = 1'b1;
          state_nxt = S_RESP;
        end else begin
          ram_raddr_a = child_l[AW-1:0];
          ram_raddr_b = child_r[AW-1:0];
          state_nxt   = S_DN_CMP;
        end
      end

      // The larger child moves up into the hole; the left child wins a tie.
      S_DN_CMP: begin
        ram_we = 1'b1;
        if (take_l || take_r) begin
          ram_wdata = best_val;
          pos_nxt   = best_idx;
          state_nxt = S_DN_CHK;
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    pos_r  <= pos_nxt;
    key_r  <= key_nxt;
    kout_r <= kout_nxt;
    stat_r <= stat_nxt;
  end

  assign req_stall     = (state_r != S_IDLE);
  assign res_valid     = (state_r == S_RESP);
  assign res.key_out   = kout_r;
  assign res.status    = stat_r;
  assign res.occupancy = occ_ext[OCC_W-1:0];

  `BMHQ_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(HEAP_DEPTH), "element count above depth")
  `BMHQ_ASSERT_IMPLY(a_wr_in_heap, ram_we, waddr_ext < cnt_ext, "write outside the live heap")
  `BMHQ_ASSERT_IMPLY(a_full_at_cap, res_valid && (res.status == STAT_FULL), cnt_full, "full status below capacity")

endmodule

@@ hw/rtl/binary_max_heap_queue.sv @@
// Binary max-heap priority queue of signed 32-bit keys: insert and extract-max.
// Top level; depends on bmhq_pkg and bmhq_engine, which holds the key RAM.
//
// One request at a time. Keys sit in a single RAM with registered reads, and
// each level that a key climbs or sinks costs one RAM read (the parent, or
// both children at once) and one compare-and-write. A full insert or an empty
// extract goes straight to its result. The result sits in an output register,
// so in_stall drops again while that result is still waiting on out_stall.
// Every request gives exactly one result. No RAM clearing is needed after
// reset.
`timescale 1ns / 1ps

module binary_max_heap_queue #(
  parameter int HEAP_DEPTH = bmhq_pkg::HEAP_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_opcode,
  input  logic signed [bmhq_pkg::KEY_W-1:0] in_key_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bmhq_pkg::KEY_W-1:0] out_key_out,
  output logic [1:0]                        out_status,
  output logic [bmhq_pkg::OCC_W-1:0]        out_occupancy
);

  import bmhq_pkg::*;

  logic         res_valid;
  logic         res_take;
  bmhq_result_t res;
  logic         out_valid_r, out_valid_nxt;
  bmhq_result_t out_res_r;

  bmhq_engine #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_op    (in_opcode),
    .req_key   (in_key_in),
    .req_stall (in_stall),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // The output register takes a new result when it is empty or being drained.
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_out   = out_res_r.key_out;
  assign out_status    = out_res_r.status;
  assign out_occupancy = out_res_r.occupancy;

endmodule
